### hw/rtl/fud_pkg.sv
// Shared types, constants and lookup functions for the fisheye undistortion map.
// Used by every module under hw/rtl; depends on nothing else.
package fud_pkg;

    localparam int IMG_WIDTH  = 2048;
    localparam int IMG_HEIGHT = 2048;

    localparam int DIV1_STEPS   = 24;
    localparam int SQRT_STEPS   = 25;
    localparam int CORDIC_STEPS = 17;
    localparam int DIV2_STEPS   = 32;

    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_X = 3'd2;
    localparam logic [2:0] REG_CENTER_Y = 3'd3;
    localparam logic [2:0] REG_DIST_K1  = 3'd4;
    localparam logic [2:0] REG_DIST_K2  = 3'd5;
    localparam logic [2:0] REG_DIST_K3  = 3'd6;
    localparam logic [2:0] REG_DIST_K4  = 3'd7;

    localparam logic [23:0] FOCAL_X_RESET  = 24'd2823004;
    localparam logic [23:0] FOCAL_Y_RESET  = 24'd2828206;
    localparam logic [23:0] CENTER_X_RESET = 24'd5306614;
    localparam logic [23:0] CENTER_Y_RESET = 24'd3859128;

    typedef struct packed {
        logic [11:0] out_col;
        logic [11:0] out_row;
    } pix_t;

    typedef struct packed {
        logic [11:0] src_col;
        logic [11:0] src_row;
        logic        in_bounds;
    } src_t;

    typedef struct packed {
        logic [24:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic [24:0] divisor;
    } div_t;

    typedef struct packed {
        logic [26:0] rem;
        logic [24:0] root;
        logic [49:0] rad;
    } sqrt_t;

    typedef struct packed {
        logic signed [27:0] x;
        logic signed [27:0] y;
        logic signed [18:0] z;
    } cordic_t;

    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [24:0]        r;
        logic               sat_x;
        logic               sat_y;
        logic [16:0]        theta;
        logic [17:0]        t2;
        logic [19:0]        t4;
        logic               neg;
        logic               ovf;
    } side_t;

    function automatic logic [16:0] atan_step(input logic [4:0] i);
        logic [16:0] a;
        case (i)
            5'd0:    a = 17'd51472;
            5'd1:    a = 17'd30386;
            5'd2:    a = 17'd16055;
            5'd3:    a = 17'd8150;
            5'd4:    a = 17'd4091;
            5'd5:    a = 17'd2047;
            5'd6:    a = 17'd1024;
            5'd7:    a = 17'd512;
            5'd8:    a = 17'd256;
            5'd9:    a = 17'd128;
            5'd10:   a = 17'd64;
            5'd11:   a = 17'd32;
            5'd12:   a = 17'd16;
            5'd13:   a = 17'd8;
            5'd14:   a = 17'd4;
            5'd15:   a = 17'd2;
            5'd16:   a = 17'd1;
            default: a = 17'd0;
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/fisheye_undistort_coordinate_map.sv
// Throughput: one transaction per cycle; the chain of division, square root and
// CORDIC cells advances as one pipeline and holds only when the output skid is full.
// Reset clears the pipeline, output and skid valid bits, and loads
// the default intrinsics with zero distortion coefficients.
module fisheye_undistort_coordinate_map
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    input  logic          pix_valid,
    output logic          pix_stall,
    input  fud_pkg::pix_t pix,
    output logic          src_valid,
    input  logic          src_stall,
    output fud_pkg::src_t src
);

    localparam int ST_MAG     = 1;
    localparam int ST_DIV1    = ST_MAG + 1;
    localparam int ST_SQ      = ST_DIV1 + fud_pkg::DIV1_STEPS;
    localparam int ST_SUM     = ST_SQ + 1;
    localparam int ST_SQRT    = ST_SUM + 1;
    localparam int ST_CORDIC  = ST_SQRT + fud_pkg::SQRT_STEPS;
    localparam int ST_T0      = ST_CORDIC + fud_pkg::CORDIC_STEPS;
    localparam int ST_T7      = ST_T0 + 7;
    localparam int ST_DIV2    = ST_T7 + 1;
    localparam int ST_SCALE   = ST_DIV2 + fud_pkg::DIV2_STEPS;
    localparam int ST_PROD    = ST_SCALE + 1;
    localparam int ST_UD      = ST_PROD + 1;
    localparam int PIPE_DEPTH = ST_UD + 1;

    localparam logic [42:0] U_LIMIT = 43'(fud_pkg::IMG_WIDTH) << 12;
    localparam logic [42:0] V_LIMIT = 43'(fud_pkg::IMG_HEIGHT) << 12;

    logic [23:0] focal_x_reg;
    logic [23:0] focal_y_reg;
    logic [23:0] center_x_reg;
    logic [23:0] center_y_reg;
    logic [19:0] dist_k1_reg;
    logic [19:0] dist_k2_reg;
    logic [19:0] dist_k3_reg;
    logic [19:0] dist_k4_reg;

    logic en;
    logic v_reg [0:PIPE_DEPTH-1];

    fud_pkg::side_t side_reg  [0:ST_SCALE];
    fud_pkg::side_t side_next [0:ST_SCALE];

    logic [23:0] magx_reg;
    logic [23:0] magy_reg;

    fud_pkg::div_t    divx_st [0:fud_pkg::DIV1_STEPS];
    fud_pkg::div_t    divy_st [0:fud_pkg::DIV1_STEPS];
    fud_pkg::sqrt_t   sqrt_st [0:fud_pkg::SQRT_STEPS];
    fud_pkg::cordic_t cord_st [0:fud_pkg::CORDIC_STEPS];
    fud_pkg::div_t    div2_st [0:fud_pkg::DIV2_STEPS];

    logic [23:0] xn;
    logic [23:0] yn;
    logic [47:0] xsq_reg;
    logic [47:0] ysq_reg;
    logic [48:0] rad_reg;

    logic [16:0] theta0;
    logic [33:0] t2_full;
    logic [35:0] t4_full;
    logic [37:0] t6_full;
    logic [39:0] t8_full;
    logic [21:0] t6_reg;
    logic [23:0] t8_reg;

    logic signed [45:0] m1_reg;
    logic signed [45:0] m2_reg;
    logic signed [45:0] m3_reg;
    logic signed [45:0] m4_reg;
    logic signed [45:0] a12_reg;
    logic signed [45:0] a34_reg;
    logic signed [45:0] acc;
    logic signed [29:0] poly_reg;
    logic signed [47:0] td_full;
    logic signed [31:0] td_reg;
    logic [29:0]        tdmag_reg;

    logic [31:0]        quo;
    logic [31:0]        quo_sat;
    logic signed [32:0] s_next;
    logic signed [32:0] s_reg;
    logic signed [57:0] px_reg;
    logic signed [57:0] py_reg;
    logic signed [42:0] ud_reg;
    logic signed [42:0] vd_reg;

    logic          res_ok;
    fud_pkg::src_t res;
    logic          take;
    logic          pipe_out;
    logic          src_valid_reg;
    logic          src_valid_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    fud_pkg::src_t src_reg;
    fud_pkg::src_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= fud_pkg::FOCAL_X_RESET;
            focal_y_reg  <= fud_pkg::FOCAL_Y_RESET;
            center_x_reg <= fud_pkg::CENTER_X_RESET;
            center_y_reg <= fud_pkg::CENTER_Y_RESET;
            dist_k1_reg  <= '0;
            dist_k2_reg  <= '0;
            dist_k3_reg  <= '0;
            dist_k4_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fud_pkg::REG_FOCAL_X:  focal_x_reg  <= cfg_data;
                fud_pkg::REG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                fud_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                fud_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                fud_pkg::REG_DIST_K1:  dist_k1_reg  <= cfg_data[19:0];
                fud_pkg::REG_DIST_K2:  dist_k2_reg  <= cfg_data[19:0];
                fud_pkg::REG_DIST_K3:  dist_k3_reg  <= cfg_data[19:0];
                fud_pkg::REG_DIST_K4:  dist_k4_reg  <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    assign en        = !skid_valid_reg;
    assign pix_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= pix_valid;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign xn = side_reg[ST_SQ-1].sat_x ? '1 : divx_st[fud_pkg::DIV1_STEPS].quo[23:0];
    assign yn = side_reg[ST_SQ-1].sat_y ? '1 : divy_st[fud_pkg::DIV1_STEPS].quo[23:0];
    assign theta0  = cord_st[fud_pkg::CORDIC_STEPS].z[18] ? '0
                                                       : cord_st[fud_pkg::CORDIC_STEPS].z[16:0];
    assign t2_full = theta0 * theta0;
    assign t4_full = side_reg[ST_T0].t2 * side_reg[ST_T0].t2;

    always_comb
    begin
        for (int k = 1; k <= ST_SCALE; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[0]    = '0;
        side_next[0].dx = $signed({1'b0, pix.out_col, 12'h000}) - $signed({1'b0, center_x_reg});
        side_next[0].dy = $signed({1'b0, pix.out_row, 12'h000}) - $signed({1'b0, center_y_reg});

        side_next[ST_DIV1].sat_x = ({8'h00, magx_reg} >= {focal_x_reg, 8'h00})
                                   && (magx_reg != '0);
        side_next[ST_DIV1].sat_y = ({8'h00, magy_reg} >= {focal_y_reg, 8'h00})
                                   && (magy_reg != '0);

        side_next[ST_CORDIC].r     = sqrt_st[fud_pkg::SQRT_STEPS].root;
        side_next[ST_T0].theta     = theta0;
        side_next[ST_T0].t2        = t2_full[33:16];
        side_next[ST_T0+1].t4      = t4_full[35:16];
        side_next[ST_T7].neg       = td_reg[31];
        side_next[ST_DIV2].ovf     = {11'h000, tdmag_reg} >= {side_reg[ST_T7].r, 16'h0000};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            magx_reg <= side_reg[0].dx[24] ? 24'(-side_reg[0].dx) : side_reg[0].dx[23:0];
            magy_reg <= side_reg[0].dy[24] ? 24'(-side_reg[0].dy) : side_reg[0].dy[23:0];
        end
    end

    // A zero focal length divides by 2^24 so that a zero offset still gives zero.
    assign divx_st[0] = '{rem: {9'h000, magx_reg[23:8]}, num: {magx_reg[7:0], 24'h000000},
                          quo: '0, divisor: {(focal_x_reg == '0), focal_x_reg}};
    assign divy_st[0] = '{rem: {9'h000, magy_reg[23:8]}, num: {magy_reg[7:0], 24'h000000},
                          quo: '0, divisor: {(focal_y_reg == '0), focal_y_reg}};

    for (genvar k = 0; k < fud_pkg::DIV1_STEPS; k++)
    begin : g_div1
        fud_div_cell u_cell_x (.clk(clk), .en(en), .din(divx_st[k]), .dout(divx_st[k+1]));
        fud_div_cell u_cell_y (.clk(clk), .en(en), .din(divy_st[k]), .dout(divy_st[k+1]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xsq_reg <= xn * xn;
            ysq_reg <= yn * yn;
            rad_reg <= {1'b0, xsq_reg} + {1'b0, ysq_reg};
        end
    end

    assign sqrt_st[0] = '{rem: '0, root: '0, rad: {1'b0, rad_reg}};

    for (genvar k = 0; k < fud_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        fud_sqrt_cell u_cell (.clk(clk), .en(en), .din(sqrt_st[k]), .dout(sqrt_st[k+1]));
    end

    assign cord_st[0] = '{x: 28'sd65536,
                          y: $signed({3'b000, sqrt_st[fud_pkg::SQRT_STEPS].root}),
                          z: '0};

    for (genvar k = 0; k < fud_pkg::CORDIC_STEPS; k++)
    begin : g_cordic
        fud_cordic_cell u_cell
        (
            .clk  (clk),
            .en   (en),
            .step (5'(k)),
            .din  (cord_st[k]),
            .dout (cord_st[k+1])
        );
    end

    assign t6_full = side_reg[ST_T0+1].t4 * side_reg[ST_T0+1].t2;
    assign t8_full = side_reg[ST_T0+1].t4 * side_reg[ST_T0+1].t4;
    assign acc     = a12_reg + a34_reg;
    assign td_full = $signed({1'b0, side_reg[ST_T0+5].theta}) * poly_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t6_reg    <= t6_full[37:16];
            t8_reg    <= t8_full[39:16];
            m1_reg    <= 46'($signed(dist_k1_reg) * $signed({1'b0, side_reg[ST_T0+2].t2}));
            m2_reg    <= 46'($signed(dist_k2_reg) * $signed({1'b0, side_reg[ST_T0+2].t4}));
            m3_reg    <= 46'($signed(dist_k3_reg) * $signed({1'b0, t6_reg}));
            m4_reg    <= 46'($signed(dist_k4_reg) * $signed({1'b0, t8_reg}));
            a12_reg   <= m1_reg + m2_reg;
            a34_reg   <= m3_reg + m4_reg;
            poly_reg  <= 30'sd65536 + 30'(acc >>> 16);
            td_reg    <= 32'(td_full >>> 16);
            tdmag_reg <= td_reg[31] ? 30'(-td_reg) : td_reg[29:0];
        end
    end

    assign div2_st[0] = '{rem: {11'h000, tdmag_reg[29:16]}, num: {tdmag_reg[15:0], 16'h0000},
                          quo: '0, divisor: side_reg[ST_T7].r};

    for (genvar k = 0; k < fud_pkg::DIV2_STEPS; k++)
    begin : g_div2
        fud_div_cell u_cell (.clk(clk), .en(en), .din(div2_st[k]), .dout(div2_st[k+1]));
    end

    assign quo     = div2_st[fud_pkg::DIV2_STEPS].quo;
    assign quo_sat = (side_reg[ST_SCALE-1].ovf || (quo > 32'h8000_0000)) ? 32'h8000_0000 : quo;

    always_comb
    begin
        if (side_reg[ST_SCALE-1].r == '0)
        begin
            s_next = 33'sd65536;
        end
        else if (side_reg[ST_SCALE-1].neg)
        begin
            s_next = -$signed({1'b0, quo_sat});
        end
        else
        begin
            s_next = $signed({1'b0, quo_sat});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg  <= s_next;
            px_reg <= 58'(side_reg[ST_SCALE].dx * s_reg);
            py_reg <= 58'(side_reg[ST_SCALE].dy * s_reg);
            ud_reg <= $signed({19'h00000, center_x_reg}) + 43'(px_reg >>> 16);
            vd_reg <= $signed({19'h00000, center_y_reg}) + 43'(py_reg >>> 16);
        end
    end

    assign res_ok = !ud_reg[42] && !vd_reg[42]
                    && ($unsigned(ud_reg) < U_LIMIT) && ($unsigned(vd_reg) < V_LIMIT);
    assign res.src_col   = res_ok ? ud_reg[23:12] : '0;
    assign res.src_row   = res_ok ? vd_reg[23:12] : '0;
    assign res.in_bounds = res_ok;

    assign take     = src_valid_reg && !src_stall;
    assign pipe_out = v_reg[PIPE_DEPTH-1] && en;

    always_comb
    begin
        src_valid_next  = src_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_out)
        begin
            if (!src_valid_reg || take)
            begin
                src_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            src_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            src_valid_reg  <= src_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                src_reg <= skid_reg;
            end
        end
        else if (pipe_out)
        begin
            if (!src_valid_reg || take)
            begin
                src_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign src_valid = src_valid_reg;
    assign src       = src_reg;

    a_skid_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> src_valid_reg)
        else $error("Skid register holds a result while the output register is empty.");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(src_valid_reg && src_stall && v_reg[PIPE_DEPTH-1]))
        else $error("Skid register filled without a stalled output and a finished item.");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && src_stall |=> skid_valid_reg && $stable(skid_reg))
        else $error("Skid register changed while the output was stalled.");

    a_out_of_bounds_zero: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid_reg && !src_reg.in_bounds |-> src_reg.src_col == '0 && src_reg.src_row == '0)
        else $error("Out-of-bounds result carries a nonzero coordinate.");

endmodule

### hw/rtl/fud_div_cell.sv
// One restoring division step: one quotient bit per cell.
// Depends on fud_pkg for the cell state type.
module fud_div_cell
(
    input  logic           clk,
    input  logic           en,
    input  fud_pkg::div_t  din,
    output fud_pkg::div_t  dout
);

    logic [25:0]   trial;
    logic          ge;
    fud_pkg::div_t cell_next;
    fud_pkg::div_t cell_reg;

    assign trial = {din.rem, din.num[31]};
    assign ge    = trial >= {1'b0, din.divisor};

    always_comb
    begin
        cell_next.rem     = ge ? 25'(trial - {1'b0, din.divisor}) : trial[24:0];
        cell_next.num     = {din.num[30:0], 1'b0};
        cell_next.quo     = {din.quo[30:0], ge};
        cell_next.divisor = din.divisor;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

### hw/rtl/fud_sqrt_cell.sv
// One digit step of the integer square root: one root bit per cell.
// Depends on fud_pkg for the cell state type.
module fud_sqrt_cell
(
    input  logic            clk,
    input  logic            en,
    input  fud_pkg::sqrt_t  din,
    output fud_pkg::sqrt_t  dout
);

    logic [28:0]    shifted;
    logic [26:0]    test;
    logic           ge;
    fud_pkg::sqrt_t cell_next;
    fud_pkg::sqrt_t cell_reg;

    assign shifted = {din.rem, din.rad[49:48]};
    assign test    = {din.root, 2'b01};
    assign ge      = shifted >= {2'b00, test};

    always_comb
    begin
        cell_next.rem  = ge ? 27'(shifted - {2'b00, test}) : shifted[26:0];
        cell_next.root = {din.root[23:0], ge};
        cell_next.rad  = {din.rad[47:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

### hw/rtl/fud_cordic_cell.sv
// One CORDIC vectoring rotation; the step index selects shift and angle.
// Depends on fud_pkg for the cell state type and the arctangent table.
module fud_cordic_cell
(
    input  logic              clk,
    input  logic              en,
    input  logic [4:0]        step,
    input  fud_pkg::cordic_t  din,
    output fud_pkg::cordic_t  dout
);

    logic signed [27:0] xs;
    logic signed [27:0] ys;
    logic signed [18:0] ang;
    fud_pkg::cordic_t   cell_next;
    fud_pkg::cordic_t   cell_reg;

    assign xs  = din.x >>> step;
    assign ys  = din.y >>> step;
    assign ang = $signed({2'b00, fud_pkg::atan_step(step)});

    always_comb
    begin
        if (!din.y[27])
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
            cell_next.z = din.z + ang;
        end
        else
        begin
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
            cell_next.z = din.z - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

### tb/fud_checker.sv
`timescale 1ns / 1ps
// Checker for the fisheye undistortion map: watches the configuration port and both channels.
// It predicts each source coordinate and compares it with what the block returns.
// Depends on fud_pkg for the register indexes and the payload types.
module fud_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    input  logic          pix_valid,
    input  logic          pix_stall,
    input  fud_pkg::pix_t pix,
    input  logic          src_valid,
    input  logic          src_stall,
    input  fud_pkg::src_t src,
    output int            failures,
    output int            pending
);

    localparam longint NORM_LIMIT  = 64'd16777215;
    localparam longint RATIO_LIMIT = 64'd2147483648;
    localparam longint ATAN_Q16 [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2, 1};

    logic [23:0]        fx, fy, cx, cy;
    logic signed [19:0] k1, k2, k3, k4;
    fud_pkg::src_t      expected_src [$];

    function automatic longint normalize(longint d, longint f);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        if (f == 0)
            return (mag != 0) ? NORM_LIMIT : 0;
        q = (mag << 16) / f;
        return (q > NORM_LIMIT) ? NORM_LIMIT : q;
    endfunction

    function automatic fud_pkg::src_t map_pixel(fud_pkg::pix_t p);
        longint dx, dy, xn, yn, r, t, t2, t4, t6, t8, acc, poly, td, s, ud, vd;
        longint cx_v, cy_v, xs, ys, q, mag;
        longint unsigned v, res, b;
        fud_pkg::src_t o;
        cx_v = longint'(cx);
        cy_v = longint'(cy);
        dx = longint'(p.out_col) * 4096 - cx_v;
        dy = longint'(p.out_row) * 4096 - cy_v;
        xn = normalize(dx, longint'(fx));
        yn = normalize(dy, longint'(fy));
        v = xn * xn + yn * yn;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        r = longint'(res);
        xs = 65536;
        ys = r;
        t = 0;
        for (int i = 0; i < 17; i++)
        begin
            q = xs >>> i;
            mag = ys >>> i;
            if (ys >= 0)
            begin
                xs = xs + mag;
                ys = ys - q;
                t = t + ATAN_Q16[i];
            end
            else
            begin
                xs = xs - mag;
                ys = ys + q;
                t = t - ATAN_Q16[i];
            end
        end
        if (t < 0)
            t = 0;
        t2 = (t * t) >>> 16;
        t4 = (t2 * t2) >>> 16;
        t6 = (t4 * t2) >>> 16;
        t8 = (t4 * t4) >>> 16;
        acc = longint'(k1) * t2 + longint'(k2) * t4 + longint'(k3) * t6 + longint'(k4) * t8;
        poly = 65536 + (acc >>> 16);
        td = (t * poly) >>> 16;
        if (r == 0)
            s = 65536;
        else
        begin
            mag = (td < 0) ? -td : td;
            q = (mag << 16) / r;
            if (q > RATIO_LIMIT)
                q = RATIO_LIMIT;
            s = (td < 0) ? -q : q;
        end
        ud = cx_v + ((dx * s) >>> 16);
        vd = cy_v + ((dy * s) >>> 16);
        if (ud >= 0 && vd >= 0 && ud < longint'(fud_pkg::IMG_WIDTH) * 4096
            && vd < longint'(fud_pkg::IMG_HEIGHT) * 4096)
        begin
            o.src_col = ud[23:12];
            o.src_row = vd[23:12];
            o.in_bounds = 1'b1;
        end
        else
            o = '0;
        return o;
    endfunction

    assign pending = expected_src.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx <= fud_pkg::FOCAL_X_RESET;
            fy <= fud_pkg::FOCAL_Y_RESET;
            cx <= fud_pkg::CENTER_X_RESET;
            cy <= fud_pkg::CENTER_Y_RESET;
            k1 <= '0;
            k2 <= '0;
            k3 <= '0;
            k4 <= '0;
            failures <= 0;
            expected_src.delete();
        end
        else
        begin
            if (pix_valid && !pix_stall)
                expected_src.push_back(map_pixel(pix));
            if (src_valid && !src_stall)
            begin
                if (expected_src.size() == 0)
                begin
                    $error("Result transaction with no pending expectation: %p", src);
                    failures <= failures + 1;
                end
                else
                begin
                    fud_pkg::src_t e;
                    e = expected_src.pop_front();
                    if (src.src_col !== e.src_col)
                        $error("src_col expected %0d actual %0d", e.src_col, src.src_col);
                    if (src.src_row !== e.src_row)
                        $error("src_row expected %0d actual %0d", e.src_row, src.src_row);
                    if (src.in_bounds !== e.in_bounds)
                        $error("in_bounds expected %0d actual %0d", e.in_bounds,
                               src.in_bounds);
                    if (src !== e)
                        failures <= failures + 1;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fud_pkg::REG_FOCAL_X:  fx <= cfg_data;
                    fud_pkg::REG_FOCAL_Y:  fy <= cfg_data;
                    fud_pkg::REG_CENTER_X: cx <= cfg_data;
                    fud_pkg::REG_CENTER_Y: cy <= cfg_data;
                    fud_pkg::REG_DIST_K1:  k1 <= cfg_data[19:0];
                    fud_pkg::REG_DIST_K2:  k2 <= cfg_data[19:0];
                    fud_pkg::REG_DIST_K3:  k3 <= cfg_data[19:0];
                    fud_pkg::REG_DIST_K4:  k4 <= cfg_data[19:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/tb_fisheye_undistort_coordinate_map.sv
`timescale 1ns / 1ps
// Top of the fisheye undistortion map testbench: clock, reset, configuration phases,
// pixel stimulus and result back-pressure. Depends on fud_pkg, the block and fud_checker.
module tb_fisheye_undistort_coordinate_map;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 130;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [23:0]   cfg_data;
    logic          pix_valid;
    logic          pix_stall;
    fud_pkg::pix_t pix;
    logic          src_valid;
    logic          src_stall;
    fud_pkg::src_t src;
    int            failures;
    int            pending;
    int            cycles = 0;
    bit            long_hold = 0;
    bit            calm = 0;

    fisheye_undistort_coordinate_map uut
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
        .src_valid(src_valid), .src_stall(src_stall), .src(src)
    );

    fud_checker u_checker
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
        .src_valid(src_valid), .src_stall(src_stall), .src(src),
        .failures(failures), .pending(pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int c;
        c = $urandom_range(0, 99);
        if (calm || c < 60)
            return 0;
        if (c < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        int hold;
        int run;
        bit hold_done;
        hold = 0;
        run = 0;
        hold_done = 0;
        src_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                hold = 400;
                hold_done = 1;
            end
            if (hold > 0)
            begin
                hold--;
                src_stall <= 1'b1;
            end
            else if (run > 0 || calm)
            begin
                run--;
                src_stall <= 1'b0;
            end
            else
            begin
                src_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0)
                    hold = pick_gap();
                else
                    run = $urandom_range(0, 12);
            end
        end
    end

    task automatic send_pixel(logic [11:0] col, logic [11:0] row);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.out_col <= col;
        pix.out_row <= row;
        pix_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !pix_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_random(int count);
        logic [11:0] col, row;
        for (int i = 0; i < count; i++)
        begin
            col = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 2047)) : 12'($urandom);
            row = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 2047)) : 12'($urandom);
            send_pixel(col, row);
        end
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
    endtask

    task automatic set_regs(logic [23:0] f_x, logic [23:0] f_y, logic [23:0] c_x,
                            logic [23:0] c_y, int d1, int d2, int d3, int d4);
        write_reg(fud_pkg::REG_FOCAL_X, f_x);
        write_reg(fud_pkg::REG_FOCAL_Y, f_y);
        write_reg(fud_pkg::REG_CENTER_X, c_x);
        write_reg(fud_pkg::REG_CENTER_Y, c_y);
        write_reg(fud_pkg::REG_DIST_K1, 24'(d1));
        write_reg(fud_pkg::REG_DIST_K2, 24'(d2));
        write_reg(fud_pkg::REG_DIST_K3, 24'(d3));
        write_reg(fud_pkg::REG_DIST_K4, 24'(d4));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_valid = 1'b0;
        pix = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd1295, 12'd942);
        send_pixel(12'd2047, 12'd2047);
        send_pixel(12'd2048, 12'd100);
        send_random(130);
        drain();

        set_regs(24'd4096000, 24'd4096000, 24'd4194304, 24'd4194304, -3277, 1500, -200, 50);
        send_pixel(12'd1024, 12'd1024);
        send_pixel(12'd1023, 12'd1024);
        send_pixel(12'd1024, 12'd0);
        send_random(20);
        long_hold = 1;
        calm = 1;
        send_random(200);
        calm = 0;
        drain();

        set_regs(24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 524287, -524288, 524287, -524288);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        send_random(60);
        pix_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        send_random(60);
        drain();

        set_regs(24'd4096, 24'd0, 24'hFFFFFF, 24'd0, -524288, 524287, -524288, 524287);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2047, 12'd1);
        send_random(110);
        drain();

        for (int ph = 0; ph < 2; ph++)
        begin
            set_regs(24'($urandom_range(2097152, 8388608)), 24'($urandom_range(2097152, 8388608)),
                     24'($urandom_range(0, 8388607)), 24'($urandom_range(0, 8388607)),
                     $urandom_range(0, 40000) - 20000, $urandom_range(0, 8000) - 4000,
                     $urandom_range(0, 1048575) - 524288, $urandom_range(0, 1048575) - 524288);
            send_random(120);
            drain();
        end

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### fisheye_undistort_coordinate_map.f
hw/rtl/fud_pkg.sv
hw/rtl/fud_div_cell.sv
hw/rtl/fud_sqrt_cell.sv
hw/rtl/fud_cordic_cell.sv
hw/rtl/fisheye_undistort_coordinate_map.sv
tb/fud_checker.sv
tb/tb_fisheye_undistort_coordinate_map.sv
